// ===== sv/ccr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle canvas rasteriser package
// Shared constants, codes, transaction types and address helpers.
// ----------------------------------------------------------------------------
package ccr_pkg;

    localparam int MAX_SIDE = 256;
    localparam int CW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RDW      = (CW > 8) ? CW : 8;
    localparam int DW       = ((CW + 9 > 20) ? CW + 9 : 20) + 1;
    localparam int MW       = DW - 1;
    localparam int SQW      = 2 * MW;
    localparam int D2W      = SQW + 1;
    localparam int ONE_Q8   = 256;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_BAD_SHAPE = 2'd1;
    localparam logic [1:0] STS_OUTSIDE   = 2'd2;

    localparam logic [7:0] KIND_OUTLINE = 8'd99;
    localparam logic [7:0] KIND_FILLED  = 8'd67;

    localparam logic [1:0] CFG_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND = 2'd2;

    localparam logic [8:0] RST_SIDE       = 9'd1;
    localparam logic [7:0] RST_BACKGROUND = 8'd32;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [19:0] center_x;
        logic signed [19:0] center_y;
        logic signed [19:0] radius;
        logic [7:0]         shape_kind;
        logic [7:0]         paint_byte;
        logic [7:0]         read_col;
        logic [7:0]         read_row;
    } t_ccr_in;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] pixel_value;
    } t_ccr_out;

    typedef struct packed {
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic [D2W-1:0]     outer;
        logic [D2W-1:0]     inner;
        logic               inner_all;
        logic               outline;
    } t_ccr_shape;

    typedef struct packed {
        logic          valid;
        logic [AW-1:0] addr;
    } t_ccr_wr;

    function automatic logic [CW-1:0] used_last(input logic [8:0] side);
        logic [CW-1:0] res;
        if (side == 9'd0) begin
            res = '0;
        end else if (int'(side) > MAX_SIDE) begin
            res = CW'(MAX_SIDE - 1);
        end else begin
            res = CW'(side - 9'd1);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] pix_addr(input logic [RDW-1:0] row,
                                               input logic [RDW-1:0] col);
        return AW'(row) * AW'(MAX_SIDE) + AW'(col);
    endfunction

endpackage

// ===== sv/circle_canvas_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle canvas rasteriser
// Byte canvas with clear, circle draw and pixel read commands.
// A clear scans every pixel in use; a draw passes setup, scan and pipeline
// drain; a read passes read and read-out; a rejected draw or read or unused
// command is answered from idle. One transaction in flight; busy drops with
// the result strobe, so the next start is taken in the strobe cycle. The
// receiver cannot stall. Reset sets control, size and background registers
// to defaults; canvas contents stay undefined until cleared or drawn.
// ----------------------------------------------------------------------------
module circle_canvas_rasterizer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ccr_pkg::t_ccr_in  i_item,
    output logic              o_done,
    output ccr_pkg::t_ccr_out o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [8:0]        i_cfg_data
);
    import ccr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_READ_OUT
    } t_state;

    t_state r_state;

    logic [8:0] r_cfg_w;
    logic [8:0] r_cfg_h;
    logic [7:0] r_bg;

    logic               r_done;
    t_ccr_out           r_result;
    logic               r_is_draw;
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      r_row;
    logic [CW-1:0]      r_last_col;
    logic [CW-1:0]      r_last_row;
    logic signed [19:0] r_radius;
    logic [7:0]         r_paint;
    t_ccr_shape         r_shape;
    logic [AW-1:0]      r_raddr;

    logic [CW-1:0]        last_col;
    logic [CW-1:0]        last_row;
    logic                 kind_ok;
    logic                 outside;
    logic                 last_pix;
    logic signed [DW-1:0] rad_less;
    logic [MW-1:0]        rad_mag;
    logic                 idle_done;
    logic [1:0]           idle_status;

    logic       pix_valid;
    t_ccr_wr    disc_wr;
    logic       disc_busy;
    logic       mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic [7:0] mem_rdata;

    always_comb begin
        last_col = used_last(r_cfg_w);
        last_row = used_last(r_cfg_h);
        kind_ok  = (i_item.shape_kind == KIND_OUTLINE) ||
                   (i_item.shape_kind == KIND_FILLED);
        outside  = (RDW'(i_item.read_col) > RDW'(last_col)) ||
                   (RDW'(i_item.read_row) > RDW'(last_row));
        last_pix = (r_col == r_last_col) && (r_row == r_last_row);
        rad_less = DW'(r_radius) - DW'(ONE_Q8);
        rad_mag  = MW'($unsigned(r_radius));
        idle_done   = 1'b0;
        idle_status = STS_OK;
        if (start) begin
            case (i_item.cmd)
                CMD_CLEAR: ;
                CMD_DRAW: begin
                    if (i_item.radius <= 20'sd0 || !kind_ok) begin
                        idle_done   = 1'b1;
                        idle_status = STS_BAD_SHAPE;
                    end
                end
                CMD_READ: begin
                    if (outside) begin
                        idle_done   = 1'b1;
                        idle_status = STS_OUTSIDE;
                    end
                end
                default: begin
                    idle_done = 1'b1;
                end
            endcase
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_result  = r_result;
    assign pix_valid = (r_state == S_SCAN) && r_is_draw;

    always_comb begin
        if (r_state == S_SCAN && !r_is_draw) begin
            mem_we    = 1'b1;
            mem_waddr = pix_addr(RDW'(r_row), RDW'(r_col));
            mem_wdata = r_bg;
        end else begin
            mem_we    = disc_wr.valid;
            mem_waddr = disc_wr.addr;
            mem_wdata = r_paint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cfg_w <= RST_SIDE;
            r_cfg_h <= RST_SIDE;
            r_bg    <= RST_BACKGROUND;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WIDTH:      r_cfg_w <= i_cfg_data;
                    CFG_HEIGHT:     r_cfg_h <= i_cfg_data;
                    CFG_BACKGROUND: r_bg    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_col      <= '0;
                    r_row      <= '0;
                    r_last_col <= last_col;
                    r_last_row <= last_row;
                    r_radius   <= i_item.radius;
                    r_paint    <= i_item.paint_byte;
                    r_shape.cx <= i_item.center_x;
                    r_shape.cy <= i_item.center_y;
                    r_shape.outline <= (i_item.shape_kind == KIND_OUTLINE);
                    r_raddr    <= pix_addr(RDW'(i_item.read_row), RDW'(i_item.read_col));
                    r_result   <= '{status: idle_status, pixel_value: 8'd0};
                    r_done     <= idle_done;
                    if (start) begin
                        case (i_item.cmd)
                            CMD_CLEAR: begin
                                r_is_draw <= 1'b0;
                                r_state   <= S_SCAN;
                            end
                            CMD_DRAW: begin
                                r_is_draw <= 1'b1;
                                if (!idle_done) begin
                                    r_state <= S_SETUP;
                                end
                            end
                            CMD_READ: begin
                                if (!idle_done) begin
                                    r_state <= S_READ;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_shape.outer     <= D2W'(SQW'(rad_mag) * SQW'(rad_mag));
                    r_shape.inner     <= D2W'(SQW'(rad_less[MW-1:0]) *
                                              SQW'(rad_less[MW-1:0]));
                    r_shape.inner_all <= rad_less[DW-1];
                    r_state           <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_col == r_last_col) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                    if (last_pix) begin
                        if (r_is_draw) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!disc_busy) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_state <= S_READ_OUT;
                end
                S_READ_OUT: begin
                    r_result.pixel_value <= mem_rdata;
                    r_done               <= 1'b1;
                    r_state              <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    ccr_disc_test u_disc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (pix_valid),
        .i_col       (r_col),
        .i_row       (r_row),
        .i_shape     (r_shape),
        .o_wr        (disc_wr),
        .o_busy      (disc_busy)
    );

    ccr_canvas_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ===== sv/ccr_canvas_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle canvas rasteriser pixel store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccr_canvas_mem (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ccr_pkg::AW-1:0] i_waddr,
    input  logic [7:0]            i_wdata,
    input  logic [ccr_pkg::AW-1:0] i_raddr,
    output logic [7:0]            o_rdata
);
    import ccr_pkg::*;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== sv/ccr_disc_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle canvas rasteriser coverage pipeline
// Stages: centre offsets and squares, registered, then a combinational squared-distance compare.
// ----------------------------------------------------------------------------
module ccr_disc_test (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pix_valid,
    input  logic [ccr_pkg::CW-1:0] i_col,
    input  logic [ccr_pkg::CW-1:0] i_row,
    input  ccr_pkg::t_ccr_shape    i_shape,
    output ccr_pkg::t_ccr_wr       o_wr,
    output logic                   o_busy
);
    import ccr_pkg::*;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        dx_abs;
    logic [DW-1:0]        dy_abs;
    logic [D2W-1:0]       d2;
    logic                 covered;

    logic          r_s1_valid;
    logic [MW-1:0] r_s1_dx_mag;
    logic [MW-1:0] r_s1_dy_mag;
    logic [AW-1:0] r_s1_addr;

    logic           r_s2_valid;
    logic [SQW-1:0] r_s2_dx2;
    logic [SQW-1:0] r_s2_dy2;
    logic [AW-1:0]  r_s2_addr;

    always_comb begin
        dx     = $signed({{(DW-CW-8){1'b0}}, i_col, 8'b0}) - DW'(i_shape.cx);
        dy     = $signed({{(DW-CW-8){1'b0}}, i_row, 8'b0}) - DW'(i_shape.cy);
        dx_abs = dx[DW-1] ? DW'(-dx) : DW'(dx);
        dy_abs = dy[DW-1] ? DW'(-dy) : DW'(dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_pix_valid;
            r_s2_valid <= r_s1_valid;
        end
        r_s1_dx_mag <= dx_abs[MW-1:0];
        r_s1_dy_mag <= dy_abs[MW-1:0];
        r_s1_addr   <= pix_addr(RDW'(i_row), RDW'(i_col));
        r_s2_dx2    <= SQW'(r_s1_dx_mag) * SQW'(r_s1_dx_mag);
        r_s2_dy2    <= SQW'(r_s1_dy_mag) * SQW'(r_s1_dy_mag);
        r_s2_addr   <= r_s1_addr;
    end

    always_comb begin
        d2      = D2W'(r_s2_dx2) + D2W'(r_s2_dy2);
        covered = (d2 <= i_shape.outer) &&
                  (!i_shape.outline || i_shape.inner_all || (d2 > i_shape.inner));
        o_wr.valid = r_s2_valid && covered;
        o_wr.addr  = r_s2_addr;
        o_busy     = r_s1_valid || r_s2_valid;
    end

endmodule

// ===== test/tb_circle_canvas_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle canvas rasteriser testbench
// Drives clear, draw, read and unused commands through the start/busy port and
// checks every result strobe against a behavioural canvas kept in the bench,
// or against the fixed result of a directed row. A short directed table
// covers reset state, field extremes and the error cases. Randomised phases
// follow, each with its own canvas size and background. Every phase opens
// with a clear so that reads only reach written pixels.
// ----------------------------------------------------------------------------
module tb_circle_canvas_rasterizer_unit;
    import ccr_pkg::*;

    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam int         LIMIT      = 1_500_000;
    localparam int         REPORT_MAX = 10;
    localparam int         PHASES     = 9;
    localparam int         PHASE_OPS  = 7;

    typedef struct {
        logic       is_cfg;
        logic [1:0] cfg_idx;
        logic [8:0] cfg_val;
        t_ccr_in    item;
        logic       fixed;
        t_ccr_out   want;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_ccr_in   i_item;
    logic      o_done;
    t_ccr_out  o_result;
    logic      i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [8:0] i_cfg_data;

    logic [7:0] canvas_model [0:MAX_SIDE*MAX_SIDE-1];
    logic [8:0] model_width;
    logic [8:0] model_height;
    logic [7:0] model_bg;

    t_ccr_out   pending_results[$];
    t_ccr_out   mon_want;
    t_dir_row   dir_tab[$];
    int         mismatch_count;
    int         cycle_count;
    int         gap_pct;

    circle_canvas_rasterizer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int side_in_use(input logic [8:0] v);
        if (v == 9'd0) begin
            return 1;
        end
        if (int'(v) > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return int'(v);
    endfunction

    task automatic predict_canvas_op(input t_ccr_in it, output t_ccr_out res);
        int     w;
        int     h;
        int     row;
        int     col;
        longint cx;
        longint cy;
        longint rad;
        longint outer;
        longint inner;
        longint dy2;
        longint d2;
        logic   inner_all;
        logic   covered;
        res = '0;
        w = side_in_use(model_width);
        h = side_in_use(model_height);
        case (it.cmd)
            CMD_CLEAR: begin
                for (row = 0; row < h; row++)
                    for (col = 0; col < w; col++)
                        canvas_model[row*MAX_SIDE + col] = model_bg;
            end
            CMD_DRAW: begin
                cx  = longint'($signed(it.center_x));
                cy  = longint'($signed(it.center_y));
                rad = longint'($signed(it.radius));
                if (rad <= 0 ||
                    (it.shape_kind != KIND_OUTLINE && it.shape_kind != KIND_FILLED)) begin
                    res.status = STS_BAD_SHAPE;
                end else begin
                    outer     = rad * rad;
                    inner_all = (rad < ONE_Q8);
                    inner     = inner_all ? 0 : (rad - ONE_Q8) * (rad - ONE_Q8);
                    for (row = 0; row < h; row++) begin
                        dy2 = (row*ONE_Q8 - cy) * (row*ONE_Q8 - cy);
                        for (col = 0; col < w; col++) begin
                            d2 = dy2 + (col*ONE_Q8 - cx) * (col*ONE_Q8 - cx);
                            covered = (d2 <= outer);
                            if (covered && it.shape_kind == KIND_OUTLINE && !inner_all)
                                covered = (d2 > inner);
                            if (covered)
                                canvas_model[row*MAX_SIDE + col] = it.paint_byte;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (int'(it.read_col) >= w || int'(it.read_row) >= h) begin
                    res.status = STS_OUTSIDE;
                end else begin
                    res.pixel_value = canvas_model[int'(it.read_row)*MAX_SIDE +
                                                   int'(it.read_col)];
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: status %0d pixel %0d",
                             o_result.status, o_result.pixel_value);
            end else begin
                mon_want = pending_results.pop_front();
                if (o_result.status !== mon_want.status ||
                    o_result.pixel_value !== mon_want.pixel_value) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: status exp %0d got %0d, pixel exp %0d got %0d",
                                 mon_want.status, o_result.status,
                                 mon_want.pixel_value, o_result.pixel_value);
                end
            end
        end
    end

    task automatic send_op(input t_ccr_in it, input logic fixed, input t_ccr_out want);
        t_ccr_out res;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_canvas_op(it, res);
        if (fixed)
            res = want;
        pending_results.push_back(res);
    endtask

    task automatic drain_and_idle(input int extra);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [8:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_WIDTH:      model_width  = val;
            CFG_HEIGHT:     model_height = val;
            CFG_BACKGROUND: model_bg     = val[7:0];
            default: ;
        endcase
    endtask

    function automatic t_dir_row op_row(input logic [1:0] cmd, input int cx, input int cy,
                                        input int rad, input logic [7:0] kind,
                                        input logic [7:0] paint, input logic [7:0] col,
                                        input logic [7:0] row, input logic fixed,
                                        input logic [1:0] sts, input logic [7:0] pix);
        t_dir_row r;
        r.is_cfg            = 1'b0;
        r.cfg_idx           = '0;
        r.cfg_val           = '0;
        r.item.cmd          = cmd;
        r.item.center_x     = 20'(cx);
        r.item.center_y     = 20'(cy);
        r.item.radius       = 20'(rad);
        r.item.shape_kind   = kind;
        r.item.paint_byte   = paint;
        r.item.read_col     = col;
        r.item.read_row     = row;
        r.fixed             = fixed;
        r.want.status       = sts;
        r.want.pixel_value  = pix;
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [1:0] idx, input logic [8:0] val);
        t_dir_row r;
        r         = op_row(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 1'b0, STS_OK, 0);
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic t_ccr_in random_op(input int w, input int h, input logic allow_paint);
        logic [95:0] raw;
        t_ccr_in     it;
        int          pick;
        int          span;
        raw  = {$urandom(), $urandom(), $urandom()};
        it   = raw[93:0];
        pick = $urandom_range(99);
        span = ((w > h) ? w : h) * ONE_Q8;
        if (!allow_paint && (pick < 40 || (pick >= 85 && pick < 92)))
            pick = 60;
        if (pick < 40) begin
            it.cmd        = CMD_DRAW;
            it.shape_kind = $urandom_range(1) ? KIND_OUTLINE : KIND_FILLED;
            if ($urandom_range(9) == 0) begin
                it.radius = 20'($urandom_range(1, 524287));
            end else begin
                it.center_x = 20'($urandom_range(0, (w + 4) * ONE_Q8) - 512);
                it.center_y = 20'($urandom_range(0, (h + 4) * ONE_Q8) - 512);
                it.radius   = ($urandom_range(3) == 0) ? 20'($urandom_range(1, 255))
                                                       : 20'($urandom_range(1, span));
            end
        end else if (pick < 50) begin
            it.cmd = CMD_DRAW;
            if ($urandom_range(1)) begin
                it.radius = $urandom_range(1) ? 20'd0 : {1'b1, 19'($urandom())};
            end else begin
                it.radius = 20'($urandom_range(1, span));
                while (it.shape_kind == KIND_OUTLINE || it.shape_kind == KIND_FILLED)
                    it.shape_kind = 8'($urandom());
            end
        end else if (pick < 85) begin
            it.cmd      = CMD_READ;
            it.read_col = 8'($urandom_range(0, w - 1));
            it.read_row = 8'($urandom_range(0, h - 1));
            if ($urandom_range(4) == 0 && !(w == MAX_SIDE && h == MAX_SIDE)) begin
                if (w < MAX_SIDE && (h == MAX_SIDE || $urandom_range(1)))
                    it.read_col = 8'($urandom_range(w, 255));
                else
                    it.read_row = 8'($urandom_range(h, 255));
            end
        end else if (pick < 92) begin
            it.cmd = CMD_CLEAR;
        end else begin
            it.cmd = CMD_NONE;
        end
        return it;
    endfunction

    initial begin
        t_ccr_in    it;
        t_ccr_out   none;
        logic [8:0] w_val;
        logic [8:0] h_val;
        int         w;
        int         h;
        int         heavy_ops;
        logic       heavy;

        none           = '0;
        start          = 1'b0;
        i_item         = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        gap_pct        = 26;
        model_width    = RST_SIDE;
        model_height   = RST_SIDE;
        model_bg       = RST_BACKGROUND;
        foreach (canvas_model[k])
            canvas_model[k] = '0;

        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 1, 0, 1'b1, STS_OUTSIDE, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 0, 255, 1'b1, STS_OUTSIDE, 0));
        dir_tab.push_back(op_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1'b1, STS_OK, 32));
        dir_tab.push_back(op_row(CMD_DRAW, 0, 0, 256, KIND_FILLED, 8'hFF, 0, 0,
                                 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1'b1, STS_OK, 8'hFF));
        dir_tab.push_back(op_row(CMD_DRAW, 0, 0, 0, KIND_FILLED, "z", 0, 0,
                                 1'b1, STS_BAD_SHAPE, 0));
        dir_tab.push_back(op_row(CMD_DRAW, 0, 0, -524288, KIND_OUTLINE, "z", 0, 0,
                                 1'b1, STS_BAD_SHAPE, 0));
        dir_tab.push_back(op_row(CMD_DRAW, 0, 0, 256, 8'h00, "z", 0, 0,
                                 1'b1, STS_BAD_SHAPE, 0));
        dir_tab.push_back(op_row(CMD_DRAW, 0, 0, 256, 8'hFF, "z", 0, 0,
                                 1'b1, STS_BAD_SHAPE, 0));
        dir_tab.push_back(op_row(CMD_NONE, -1, -1, -1, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 1'b1, STS_OK, 0));
        dir_tab.push_back(cfg_row(CFG_WIDTH, 9'd16));
        dir_tab.push_back(cfg_row(CFG_HEIGHT, 9'd12));
        dir_tab.push_back(cfg_row(CFG_BACKGROUND, 9'd255));
        dir_tab.push_back(op_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 15, 11, 1'b1, STS_OK, 8'hFF));
        dir_tab.push_back(op_row(CMD_DRAW, 7*256 + 128, 5*256 + 128, 5*256, KIND_OUTLINE,
                                 "o", 0, 0, 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_DRAW, 3*256, 3*256, 128, KIND_OUTLINE, "x", 0, 0,
                                 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_DRAW, 15*256, 11*256, 3*256, KIND_FILLED, 8'h00, 0, 0,
                                 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_DRAW, -524288, -524288, 524287, KIND_FILLED, "m", 0, 0,
                                 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_DRAW, 524287, 524287, 524287, KIND_OUTLINE, "n", 0, 0,
                                 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 7, 0, 1'b0, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 3, 3, 1'b0, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 13, 11, 1'b0, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 2, 5, 1'b0, STS_OK, 0));
        dir_tab.push_back(cfg_row(CFG_WIDTH, 9'd0));
        dir_tab.push_back(cfg_row(CFG_HEIGHT, 9'd511));
        dir_tab.push_back(cfg_row(CFG_BACKGROUND, 9'd0));
        dir_tab.push_back(op_row(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 0, 255, 1'b1, STS_OK, 0));
        dir_tab.push_back(op_row(CMD_READ, 0, 0, 0, 0, 0, 1, 0, 1'b1, STS_OUTSIDE, 0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                drain_and_idle(4);
                write_cfg(dir_tab[k].cfg_idx, dir_tab[k].cfg_val);
            end else begin
                send_op(dir_tab[k].item, dir_tab[k].fixed, dir_tab[k].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            gap_pct = (ph < 3) ? 26 : ((ph < 6) ? 80 : 0);
            case (ph)
                2:       begin w_val = 9'd256; h_val = 9'd3;   end
                4:       begin w_val = 9'd0;   h_val = 9'd256; end
                6:       begin w_val = 9'd511; h_val = 9'd511; end
                8:       begin w_val = 9'($urandom_range(257, 510)); h_val = 9'd2; end
                default: begin
                    w_val = 9'($urandom_range(1, 24));
                    h_val = 9'($urandom_range(1, 20));
                end
            endcase
            drain_and_idle(4);
            write_cfg(CFG_WIDTH, w_val);
            write_cfg(CFG_HEIGHT, h_val);
            write_cfg(CFG_BACKGROUND, 9'($urandom_range(0, 255)));
            w         = side_in_use(model_width);
            h         = side_in_use(model_height);
            heavy     = (w * h > 4096);
            heavy_ops = 0;
            it        = random_op(w, h, 1'b0);
            it.cmd    = CMD_CLEAR;
            send_op(it, 1'b0, none);
            for (int n = 0; n < PHASE_OPS; n++) begin
                it = random_op(w, h, !heavy || heavy_ops < 2);
                if (it.cmd == CMD_CLEAR || it.cmd == CMD_DRAW)
                    heavy_ops++;
                send_op(it, 1'b0, none);
            end
        end

        drain_and_idle(20);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ccr_pkg.sv
sv/ccr_canvas_mem.sv
sv/ccr_disc_test.sv
sv/circle_canvas_rasterizer_unit.sv
test/tb_circle_canvas_rasterizer_unit.sv
